FILE: hdl/lbp_pkg.sv
// lbp_pkg: shared types and constants of the log band power averager.
// No dependencies; every other file uses it.
package lbp_pkg;

    localparam int SUM_W       = 64;   // band power sum
    localparam int MEAN_W      = 48;   // reported mean
    localparam int BAND_NO_W   = 5;    // reported band number
    localparam int BAND_WID_W  = 13;   // band width in bins, up to 8191
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int RADIX_BITS  = 4;    // quotient bits per divider cycle
    localparam int DIV_STEPS   = SUM_W / RADIX_BITS;

    localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};

    // one finished band waiting for its division
    typedef struct packed {
        logic [BAND_NO_W-1:0]  band_no;
        logic [SUM_W-1:0]      sum;
        logic [BAND_WID_W-1:0] width;
        logic                  final_band;
    } t_job;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               not_empty;
    } t_q_stat;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_RUN,
        DS_DONE
    } t_div_state;

endpackage

FILE: hdl/lbp_if.sv
// Stream interfaces of the log band power averager: sample input, band output.
// Depends on lbp_pkg for the output field widths.
interface lbp_in_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic                           frame_start;
    logic signed [SAMPLE_WIDTH-1:0] re_part;
    logic signed [SAMPLE_WIDTH-1:0] im_part;

    modport source (output valid, frame_start, re_part, im_part, input ready);
    modport sink   (input valid, frame_start, re_part, im_part, output ready);
endinterface

interface lbp_out_if;
    logic                           valid;
    logic                           ready;
    logic [lbp_pkg::BAND_NO_W-1:0]  band_number;
    logic [lbp_pkg::MEAN_W-1:0]     mean_power;
    logic                           final_band;

    modport source (output valid, band_number, mean_power, final_band, input ready);
    modport sink   (input valid, band_number, mean_power, final_band, output ready);
endinterface

FILE: hdl/lbp_front.sv
// lbp_front: takes samples, tracks index and band, squares and accumulates power,
// and pushes each finished band sum to the job queue. Depends on lbp_pkg, lbp_if.
module lbp_front #(
    parameter int NUM_BANDS       = 32,
    parameter int FFT_HALF_POINTS = 1024,
    parameter int SAMPLE_WIDTH    = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lbp_in_if.sink           i_in,
    input  lbp_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output lbp_pkg::t_job    o_job
);
    import lbp_pkg::*;

    localparam int EW    = $clog2(FFT_HALF_POINTS + 1);
    localparam int BW    = $clog2(NUM_BANDS + 1);
    localparam int SW    = SAMPLE_WIDTH;
    localparam int IDX_W = 16;
    localparam logic [IDX_W-1:0] INDEX_LIMIT = {IDX_W{1'b1}};
    localparam int LOW_FREQ  = 318;
    localparam int HIGH_FREQ = 2000;
    localparam int RATE_SPAN = 2756;

    typedef logic [NUM_BANDS:0][EW-1:0] t_edges;
    typedef logic [NUM_BANDS:0][BW-1:0] t_bands;

    // log2 with 32 fraction bits, rounded down
    function automatic logic [63:0] fixed_log2(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] frac;
        int          n;
        x = (x_in == 64'd0) ? 64'd1 : x_in;
        n = 0;
        while (n < 63 && (x >> (n + 1)) != 64'd0) n++;
        y    = (x << 30) >> n;
        frac = 64'd0;
        for (int b = 31; b >= 0; b--) begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30)) begin
                y       = y >> 1;
                frac[b] = 1'b1;
            end
        end
        return (64'(n) << 32) | frac;
    endfunction

    // band edges compared in the log domain, clamped to [1, FFT_HALF_POINTS]
    function automatic t_edges build_edges();
        t_edges      e;
        logic [63:0] llo;
        logic [63:0] lhi;
        logic [63:0] lscale;
        logic [63:0] lhs;
        logic [63:0] rhs;
        int          k;
        logic        stop;
        llo    = fixed_log2(64'(LOW_FREQ));
        lhi    = fixed_log2(64'(HIGH_FREQ));
        lscale = 64'(NUM_BANDS) * fixed_log2(64'(2 * FFT_HALF_POINTS));
        k      = 1;
        for (int i = 0; i <= NUM_BANDS; i++) begin
            lhs  = 64'(NUM_BANDS - i) * llo + 64'(i) * lhi + lscale;
            stop = 1'b0;
            while (k < FFT_HALF_POINTS && !stop) begin
                rhs = 64'(NUM_BANDS) * fixed_log2(64'(2 * k + 1) * 64'(RATE_SPAN));
                if (lhs >= rhs) k++;
                else stop = 1'b1;
            end
            e[i] = EW'(k);
        end
        return e;
    endfunction

    function automatic t_edges build_hi(input t_edges e);
        t_edges h;
        for (int b = 0; b < NUM_BANDS; b++) h[b] = e[b + 1];
        h[NUM_BANDS] = '0;
        return h;
    endfunction

    // band that follows b, skipping empty bands; NUM_BANDS when none is left
    function automatic t_bands build_next(input t_edges e);
        t_bands nx;
        int     nf;
        nf = NUM_BANDS;
        nx[NUM_BANDS] = BW'(NUM_BANDS);
        for (int b = NUM_BANDS - 1; b >= 0; b--) begin
            nx[b] = BW'(nf);
            if (e[b] != e[b + 1]) nf = b;
        end
        return nx;
    endfunction

    function automatic int first_band(input t_edges e);
        int nf;
        nf = NUM_BANDS;
        for (int b = NUM_BANDS - 1; b >= 0; b--) begin
            if (e[b] != e[b + 1]) nf = b;
        end
        return nf;
    endfunction

    localparam t_edges          EDGE_LO    = build_edges();
    localparam t_edges          EDGE_HI    = build_hi(EDGE_LO);
    localparam t_bands          NEXT_BAND  = build_next(EDGE_LO);
    localparam logic [BW-1:0]   FIRST_BAND = BW'(first_band(EDGE_LO));

    // index / band state
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [BW-1:0]    r_band, n_band;

    // stage A: squares and band flags
    logic                  r_p_valid;
    logic                  r_p_clr;
    logic                  r_p_inb;
    logic                  r_p_last;
    logic [2*SW-1:0]       r_sq_re;
    logic [2*SW-1:0]       r_sq_im;
    logic [BAND_NO_W-1:0]  r_p_band;
    logic [BAND_WID_W-1:0] r_p_width;
    logic                  r_p_final;

    // stage B: running sum
    logic [SUM_W-1:0] r_sum, n_sum;

    logic             accept;
    logic             pending;
    logic [IDX_W-1:0] eff_idx;
    logic [BW-1:0]    eff_band;
    logic [EW-1:0]    lo;
    logic [EW-1:0]    hi;
    logic             in_band;
    logic             last;
    logic [SW-1:0]    mag_re;
    logic [SW-1:0]    mag_im;
    logic [SUM_W-1:0] pow;
    logic [SUM_W-1:0] base;
    logic [SUM_W:0]   sum_ext;
    logic [SUM_W-1:0] acc;

    // a band held in stage A still needs a queue slot
    assign pending    = r_p_valid & r_p_inb & r_p_last;
    assign i_in.ready = ({1'b0, i_q_stat.count} + (Q_CNT_W + 1)'(pending))
                        < (Q_CNT_W + 1)'(QUEUE_DEPTH);
    assign accept     = i_in.valid & i_in.ready;

    always_comb begin
        eff_idx  = i_in.frame_start ? '0 : r_idx;
        eff_band = i_in.frame_start ? FIRST_BAND : r_band;
        lo       = EDGE_LO[eff_band];
        hi       = EDGE_HI[eff_band];
        in_band  = (eff_band < BW'(NUM_BANDS)) && (eff_idx >= IDX_W'(lo)) && (eff_idx < IDX_W'(hi));
        last     = ((IDX_W + 1)'(eff_idx) + (IDX_W + 1)'(1)) == (IDX_W + 1)'(hi);
        n_idx    = r_idx;
        n_band   = r_band;
        if (accept) begin
            n_idx  = (eff_idx == INDEX_LIMIT) ? eff_idx : eff_idx + IDX_W'(1);
            n_band = (in_band && last) ? NEXT_BAND[eff_band] : eff_band;
        end
    end

    assign mag_re = i_in.re_part[SW-1] ? (~i_in.re_part + SW'(1)) : i_in.re_part;
    assign mag_im = i_in.im_part[SW-1] ? (~i_in.im_part + SW'(1)) : i_in.im_part;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_band    <= FIRST_BAND;
            r_p_valid <= 1'b0;
            r_sum     <= '0;
        end else begin
            r_idx     <= n_idx;
            r_band    <= n_band;
            r_p_valid <= accept;
            r_sum     <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_clr   <= i_in.frame_start;
            r_p_inb   <= in_band;
            r_p_last  <= last;
            r_sq_re   <= (2 * SW)'(mag_re) * (2 * SW)'(mag_re);
            r_sq_im   <= (2 * SW)'(mag_im) * (2 * SW)'(mag_im);
            r_p_band  <= BAND_NO_W'(eff_band);
            r_p_width <= BAND_WID_W'(hi - lo);
            r_p_final <= NEXT_BAND[eff_band] == BW'(NUM_BANDS);
        end
    end

    // each square is at most 2^62, so their sum fits the sum width
    always_comb begin
        pow     = SUM_W'(r_sq_re) + SUM_W'(r_sq_im);
        base    = (r_p_valid && r_p_clr) ? '0 : r_sum;
        sum_ext = {1'b0, base} + {1'b0, pow};
        acc     = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
        n_sum   = base;
        o_push  = 1'b0;
        if (r_p_valid && r_p_inb) begin
            if (r_p_last) begin
                o_push = 1'b1;
                n_sum  = '0;
            end else begin
                n_sum  = acc;
            end
        end
        o_job.band_no    = r_p_band;
        o_job.sum        = acc;
        o_job.width      = r_p_width;
        o_job.final_band = r_p_final;
    end

`ifndef ASSERT_OFF
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_q_stat.count < Q_CNT_W'(QUEUE_DEPTH)))
        else $error("band pushed into a full queue");
    a_push_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_job.width != '0))
        else $error("empty band pushed");
`endif

endmodule

FILE: hdl/lbp_queue.sv
// lbp_queue: short register FIFO of finished band sums between front and divider.
// Depends on lbp_pkg.
module lbp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lbp_pkg::t_job    i_job,
    input  logic             i_pop,
    output lbp_pkg::t_job    o_head,
    output lbp_pkg::t_q_stat o_stat
);
    import lbp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_job               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + PTR_W'(1);
            if (i_pop)  r_rd <= r_rd + PTR_W'(1);
            r_count <= r_count + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    assign o_head           = r_mem[r_rd];
    assign o_stat.count     = r_count;
    assign o_stat.not_empty = r_count != '0;

`ifndef ASSERT_OFF
    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from an empty queue");
`endif

endmodule

FILE: hdl/lbp_divider.sv
// lbp_divider: radix-16 restoring divide of a band sum by its width, saturates
// the mean and holds it in the output register. Depends on lbp_pkg, lbp_if.
module lbp_divider (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lbp_pkg::t_job    i_head,
    input  lbp_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    lbp_out_if.source        o_out
);
    import lbp_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    t_div_state r_state, n_state;

    logic [SUM_W-1:0]      r_q, n_q;
    logic [BAND_WID_W-1:0] r_rem, n_rem;
    logic [BAND_WID_W-1:0] r_div;
    logic [STEP_W-1:0]     r_step;
    logic [BAND_NO_W-1:0]  r_band;
    logic                  r_final;
    logic [MEAN_W-1:0]     r_mean;
    logic                  load;

    always_comb begin
        n_state = r_state;
        case (r_state)
            DS_IDLE: if (i_q_stat.not_empty) n_state = DS_RUN;
            DS_RUN:  if (r_step == LAST_STEP) n_state = DS_DONE;
            DS_DONE: begin
                if (o_out.ready) n_state = i_q_stat.not_empty ? DS_RUN : DS_IDLE;
            end
            default: n_state = DS_IDLE;
        endcase
    end

    always_comb begin
        load        = 1'b0;
        o_out.valid = 1'b0;
        case (r_state)
            DS_IDLE: load = i_q_stat.not_empty;
            DS_RUN:  load = 1'b0;
            DS_DONE: begin
                o_out.valid = 1'b1;
                load        = o_out.ready & i_q_stat.not_empty;
            end
            default: load = 1'b0;
        endcase
    end

    assign o_pop = load;

    // four compare-subtract steps per cycle; remainder stays below the width
    always_comb begin : div_step
        logic [BAND_WID_W:0] trial;
        n_q   = r_q;
        n_rem = r_rem;
        for (int s = 0; s < RADIX_BITS; s++) begin
            trial = {n_rem, n_q[SUM_W-1]};
            n_q   = {n_q[SUM_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                n_rem  = BAND_WID_W'(trial - {1'b0, r_div});
                n_q[0] = 1'b1;
            end else begin
                n_rem  = trial[BAND_WID_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DS_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (load)                  r_step <= '0;
            else if (r_state == DS_RUN) r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_q     <= i_head.sum;
            r_rem   <= '0;
            r_div   <= i_head.width;
            r_band  <= i_head.band_no;
            r_final <= i_head.final_band;
        end else if (r_state == DS_RUN) begin
            r_q   <= n_q;
            r_rem <= n_rem;
            if (r_step == LAST_STEP) begin
                r_mean <= (n_q[SUM_W-1:MEAN_W] != '0) ? MEAN_MAX : n_q[MEAN_W-1:0];
            end
        end
    end

    assign o_out.band_number = r_band;
    assign o_out.mean_power  = r_mean;
    assign o_out.final_band  = r_final;

`ifndef ASSERT_OFF
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DS_RUN) |-> (r_rem < r_div))
        else $error("divider remainder out of range");
    a_run_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DS_RUN && r_step == '0) |-> $past(load))
        else $error("divide started without a job");
`endif

endmodule

FILE: hdl/log_band_power_averager_top.sv
// log_band_power_averager_top: mean power over log-spaced FFT bands.
// Depends on lbp_pkg, lbp_if, lbp_front, lbp_queue, lbp_divider.
//
//  channel | dir | beat payload                          | accepted when
//  --------+-----+---------------------------------------+------------------------
//  i_in    | in  | frame_start, re_part, im_part         | i_in.valid & i_in.ready
//  o_out   | out | band_number, mean_power, final_band   | o_out.valid & o_out.ready
//
// Cycles: the front takes one sample beat per cycle while the job queue has room.
// The divider loads one finished band at a time and works it in DIV_STEPS steps of
// 4 quotient bits each; that divider sets the band rate.
// Reset: synchronous, active low; the band edge ROM is constant logic, so there
// is no clearing pass and the block takes beats the cycle after reset.
// Stalls: i_in.ready drops while the queued band sums plus a band about to be
// queued fill all four slots; a result held on o_out stalls only the divider,
// the front keeps summing until the queue fills.
module log_band_power_averager_top #(
    parameter int NUM_BANDS       = 32,
    parameter int FFT_HALF_POINTS = 1024,
    parameter int SAMPLE_WIDTH    = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lbp_in_if.sink    i_in,
    lbp_out_if.source o_out
);
    import lbp_pkg::*;

    t_job    push_job;
    logic    push;
    t_job    head_job;
    logic    pop;
    t_q_stat q_stat;

    // front: index tracking, band lookup, squaring, accumulation
    lbp_front #(
        .NUM_BANDS       (NUM_BANDS),
        .FFT_HALF_POINTS (FFT_HALF_POINTS),
        .SAMPLE_WIDTH    (SAMPLE_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (push_job)
    );

    // decoupling queue of finished band sums
    lbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (q_stat)
    );

    // back: sum / width and the output register
    lbp_divider u_divider (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_job),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

FILE: dv/testbench.sv
// Self-checking bench for log_band_power_averager_top: streams FFT frames and
// checks each band mean against an in-bench band power predictor.
// Depends on hdl/lbp_pkg.sv, hdl/lbp_if.sv and the block's RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lbp_pkg::*;

    localparam int NUM_BANDS       = 32;
    localparam int FFT_HALF_POINTS = 1024;
    localparam int SW              = 24;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 9;
    localparam int LOW_HZ        = 318;
    localparam int HIGH_HZ       = 2000;
    localparam int RATE_SPAN     = 2756;
    localparam int INDEX_CAP     = 65535;
    localparam int ITEM_TARGET   = 1500;   // total feed entries (bin beats and pauses) queued for the run
    localparam int STALL_LIMIT   = 4000;   // cycles with no beat on either side
    localparam int SETTLE_CYCLES = 100;

    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};

    typedef enum int {
        STYLE_FULL,
        STYLE_EXTREME,
        STYLE_SMALL
    } t_sample_style;

    typedef struct {
        logic                 drain;  // sender pauses here until all bands are out
        logic                 fs;
        logic signed [SW-1:0] re;
        logic signed [SW-1:0] im;
    } t_bin_beat;

    typedef struct {
        logic [BAND_NO_W-1:0] band_no;
        logic [MEAN_W-1:0]    mean;
        logic                 last;
    } t_band_mean;

    logic i_clk;
    logic i_rst_n;

    lbp_in_if #(.SAMPLE_WIDTH(SW)) in_if ();
    lbp_out_if                     out_if ();

    log_band_power_averager_top #(
        .NUM_BANDS      (NUM_BANDS),
        .FFT_HALF_POINTS(FFT_HALF_POINTS),
        .SAMPLE_WIDTH   (SW)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // band edge table, rebuilt here from the log-domain formula
    int bound [0:NUM_BANDS];

    // predictor state
    int unsigned      bin_idx;
    int               band_cur;
    logic [SUM_W-1:0] band_sum;

    t_bin_beat  bin_feed [$];
    t_band_mean pending_bands [$];

    int  err_count;
    int  idle_cycles;
    bit  in_fire;
    bit  out_fire;

    // sender burst shaping and receiver stall pattern
    int  burst_left;
    int  gap_left;
    int  rx_mode;
    int  rx_mode_left;
    int  rx_stall_left;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // log2 of x with 32 fraction bits, rounded down (x >= 1)
    function automatic logic [63:0] log2_q32(input logic [63:0] x);
        int          msb;
        logic [63:0] y;
        logic [63:0] frac;
        msb  = 0;
        frac = '0;
        if (x == 0) x = 1;
        while (msb < 63 && (x >> (msb + 1)) != 0) msb++;
        y = (x << 30) >> msb;
        for (int b = 31; b >= 0; b--) begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30)) begin
                y       = y >> 1;
                frac[b] = 1'b1;
            end
        end
        return (64'(msb) << 32) | frac;
    endfunction

    // edge i = round(H * f_i / span), compared exactly in the log domain
    function automatic void build_bounds();
        logic [63:0] lo_log;
        logic [63:0] hi_log;
        logic [63:0] scale;
        logic [63:0] lhs;
        logic [63:0] rhs;
        int          k;
        lo_log = log2_q32(64'(LOW_HZ));
        hi_log = log2_q32(64'(HIGH_HZ));
        scale  = 64'(NUM_BANDS) * log2_q32(64'(2 * FFT_HALF_POINTS));
        k      = 1;
        for (int i = 0; i <= NUM_BANDS; i++) begin
            lhs = 64'(NUM_BANDS - i) * lo_log + 64'(i) * hi_log + scale;
            while (k < FFT_HALF_POINTS) begin
                rhs = 64'(NUM_BANDS) * log2_q32(64'(2 * k + 1) * 64'(RATE_SPAN));
                if (lhs >= rhs) k++;
                else break;
            end
            bound[i] = k;
        end
    endfunction

    function automatic int first_filled(input int b);
        while (b < NUM_BANDS && bound[b] == bound[b + 1]) b++;
        return b;
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [SW-1:0] v);
        longint s;
        s = v;
        return (s < 0) ? 64'(-s) : 64'(s);
    endfunction

    // one accepted bin: sum its power into the current band, close the band on its last bin
    function automatic void accumulate_bin(input logic fs, input logic signed [SW-1:0] re,
                                           input logic signed [SW-1:0] im);
        logic [63:0] pw_re;
        logic [63:0] pw_im;
        logic [64:0] wide;
        logic [63:0] pw;
        logic [63:0] mean;
        int          nxt;
        t_band_mean  res;
        if (fs) begin
            bin_idx  = 0;
            band_sum = '0;
            band_cur = first_filled(0);
        end
        if (band_cur < NUM_BANDS && bin_idx >= bound[band_cur]
                && bin_idx < bound[band_cur + 1]) begin
            pw_re    = magnitude(re) * magnitude(re);
            pw_im    = magnitude(im) * magnitude(im);
            wide     = {1'b0, pw_re} + {1'b0, pw_im};
            pw       = wide[64] ? '1 : wide[63:0];
            wide     = {1'b0, band_sum} + {1'b0, pw};
            band_sum = wide[64] ? '1 : wide[63:0];
            if (bin_idx + 1 == bound[band_cur + 1]) begin
                mean = band_sum / 64'(bound[band_cur + 1] - bound[band_cur]);
                if (mean > 64'(MEAN_MAX)) mean = 64'(MEAN_MAX);
                nxt          = first_filled(band_cur + 1);
                res.band_no  = band_cur[BAND_NO_W-1:0];
                res.mean     = mean[MEAN_W-1:0];
                res.last     = (nxt >= NUM_BANDS);
                pending_bands.push_back(res);
                band_sum = '0;
                band_cur = nxt;
            end
        end
        if (bin_idx < INDEX_CAP) bin_idx++;
    endfunction

    function automatic logic signed [SW-1:0] pick_sample(input t_sample_style style);
        logic signed [SW-1:0] v;
        case (style)
            STYLE_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       v = S_MIN;
                    1:       v = S_MAX;
                    2:       v = '0;
                    3:       v = '1;
                    default: v = SW'(1);
                endcase
            end
            STYLE_SMALL: v = SW'($urandom_range(0, 15)) - SW'(8);
            default:     v = SW'($urandom());
        endcase
        return v;
    endfunction

    function automatic void push_bin(input logic fs, input logic signed [SW-1:0] re,
                                     input logic signed [SW-1:0] im);
        t_bin_beat beat;
        beat.drain = 1'b0;
        beat.fs    = fs;
        beat.re    = re;
        beat.im    = im;
        bin_feed.push_back(beat);
    endfunction

    function automatic void push_pause();
        t_bin_beat beat;
        beat.drain = 1'b1;
        beat.fs    = 1'b0;
        beat.re    = '0;
        beat.im    = '0;
        bin_feed.push_back(beat);
    endfunction

    // frame_start on the first bin; frames shorter or longer than H are allowed
    task automatic push_frame(input int len, input t_sample_style style);
        for (int i = 0; i < len; i++) begin
            push_bin(i == 0, pick_sample(style), pick_sample(style));
        end
    endtask

    // Sample input beats and output beats at the rising edge. Output check comes
    // first: a band can only leave the divider in a later cycle than its last bin.
    always @(posedge i_clk) begin
        t_band_mean want;
        in_fire  = i_rst_n && ((in_if.valid & in_if.ready) === 1'b1);
        out_fire = i_rst_n && ((out_if.valid & out_if.ready) === 1'b1);
        if (out_fire) begin
            if (pending_bands.size() == 0) begin
                $error("unexpected band beat: band_number %0d mean_power %0d final_band %0b",
                       out_if.band_number, out_if.mean_power, out_if.final_band);
                err_count++;
            end else begin
                want = pending_bands.pop_front();
                if (out_if.band_number !== want.band_no) begin
                    $error("band_number: expected %0d, actual %0d",
                           want.band_no, out_if.band_number);
                    err_count++;
                end
                if (out_if.mean_power !== want.mean) begin
                    $error("mean_power: expected %0d, actual %0d",
                           want.mean, out_if.mean_power);
                    err_count++;
                end
                if (out_if.final_band !== want.last) begin
                    $error("final_band: expected %0b, actual %0b",
                           want.last, out_if.final_band);
                    err_count++;
                end
            end
        end
        if (in_fire) accumulate_bin(in_if.frame_start, in_if.re_part, in_if.im_part);
        // watchdog: a hung handshake on either side ends the run
        if (!i_rst_n || in_fire || out_fire) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("log_band_power_averager_top: mismatch");
            $finish;
        end
    end

    // Sender: bursts of random length, random gaps, and pause markers that hold
    // off until every predicted band has come out.
    always @(negedge i_clk) begin
        t_bin_beat beat;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (in_if.valid === 1'b1 && !in_fire) begin
            // beat still offered, hold it
        end else if (gap_left != 0) begin
            gap_left--;
            in_if.valid <= 1'b0;
        end else if (bin_feed.size() == 0) begin
            in_if.valid <= 1'b0;
        end else if (bin_feed[0].drain) begin
            in_if.valid <= 1'b0;
            if (pending_bands.size() == 0) void'(bin_feed.pop_front());
        end else begin
            beat = bin_feed.pop_front();
            in_if.valid       <= 1'b1;
            in_if.frame_start <= beat.fs;
            in_if.re_part     <= beat.re;
            in_if.im_part     <= beat.im;
            if (burst_left != 0) begin
                burst_left--;
            end else begin
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                                         : $urandom_range(1, 48);
                if ($urandom_range(0, 3) == 0) gap_left = 0;
                else if ($urandom_range(0, 9) == 0) gap_left = $urandom_range(16, 40);
                else gap_left = $urandom_range(1, 5);
            end
        end
    end

    // Receiver: switches between always ready, random ready and long stalls.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(32, 256);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0: out_if.ready <= 1'b1;
                1: out_if.ready <= ($urandom_range(0, 9) < 7);
                default: begin
                    if (rx_stall_left != 0) begin
                        rx_stall_left--;
                        out_if.ready <= 1'b0;
                    end else begin
                        out_if.ready <= 1'b1;
                        if ($urandom_range(0, 7) == 0) rx_stall_left = $urandom_range(1, 30);
                    end
                end
            endcase
        end
    end

    initial begin
        int            b0;
        int            b1;
        int            len;
        t_sample_style style;

        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.frame_start = 1'b0;
        in_if.re_part     = '0;
        in_if.im_part     = '0;
        out_if.ready      = 1'b0;
        err_count         = 0;
        idle_cycles       = 0;
        burst_left        = 0;
        gap_left          = 0;
        rx_mode           = 0;
        rx_mode_left      = 0;
        rx_stall_left     = 0;

        build_bounds();
        bin_idx  = 0;
        band_sum = '0;
        band_cur = first_filled(0);
        b0       = first_filled(0);
        b1       = first_filled(b0 + 1);

        // Directed. First frame has no frame_start: the index must come from reset.
        // Bins below the lowest edge are ignored; first band at full negative scale
        // on both parts, second band with mixed extremes.
        for (int i = 0; i < bound[b1 + 1]; i++) begin
            if (i < bound[b0]) push_bin(1'b0, '0, '0);
            else if (i < bound[b0 + 1]) push_bin(1'b0, S_MIN, S_MIN);
            else push_bin(1'b0, (i % 2) ? S_MAX : S_MIN, (i % 2) ? S_MIN : S_MAX);
        end
        // a few bins into the next band, then a restart drops the partial sum
        for (int i = 0; i < 3; i++) push_bin(1'b0, SW'(i + 1), -SW'(i + 1));
        push_bin(1'b1, S_MAX, S_MAX);
        // restarted frame: zero power in the first band
        for (int i = 1; i < bound[b0 + 1]; i++) push_bin(1'b0, '0, '0);
        push_pause();

        // Random frames: mostly whole frames, some cut short by an early restart,
        // some running past the last bin; the last one is clipped to the budget.
        while (bin_feed.size() < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1:    style = STYLE_EXTREME;
                2:       style = STYLE_SMALL;
                default: style = STYLE_FULL;
            endcase
            case ($urandom_range(0, 9))
                7:       len = $urandom_range(1, FFT_HALF_POINTS - 1);
                8:       len = FFT_HALF_POINTS + $urandom_range(1, 300);
                default: len = FFT_HALF_POINTS;
            endcase
            if (len > ITEM_TARGET - bin_feed.size()) len = ITEM_TARGET - bin_feed.size();
            push_frame(len, style);
            if ($urandom_range(0, 3) == 0) push_pause();
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (bin_feed.size() != 0 || in_if.valid === 1'b1) @(posedge i_clk);
        while (pending_bands.size() != 0) @(posedge i_clk);
        // catch any band beat that should not be there
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("log_band_power_averager_top: match");
        end else begin
            $display("log_band_power_averager_top: mismatch");
        end
        $finish;
    end

endmodule
